FILE: design/sparse_neighbor_pixel_counter_macros.svh
// ----------------------------------------------------------------------------
// sparse neighbour pixel counter assertion macros
// shared property forms, clocked on clk and held off by rst_n
// ----------------------------------------------------------------------------
`ifndef SPARSE_NEIGHBOR_PIXEL_COUNTER_MACROS_SVH
`define SPARSE_NEIGHBOR_PIXEL_COUNTER_MACROS_SVH

// consequent checked in the same cycle
`define SNPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define SNPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/snpc_pkg.sv
// ----------------------------------------------------------------------------
// snpc_pkg
// types and constants shared by the sparse neighbour pixel counter
// ----------------------------------------------------------------------------
package snpc_pkg;

  localparam int ROW_WIDTH_W = 9;
  localparam int THRESH_W    = 4;
  localparam int SUM_W       = 24;
  localparam int IDX_W       = 2;
  localparam int CFG_W       = 9;

  localparam logic [IDX_W-1:0]       REG_ROW_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0]       REG_THRESHOLD = 2'd1;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 9'd256;
  localparam logic [THRESH_W-1:0]    THRESH_RST    = 4'd4;

  // window without its centre
  localparam logic [8:0] NB_MASK = 9'h1EF;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FILL,
    ST_BELOW,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic push;
    logic use_input;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic row_end;
    logic out_free;
  } status_t;

endpackage

FILE: design/snpc_ctrl.sv
// ----------------------------------------------------------------------------
// snpc_ctrl
// sequencer: pixel intake, end-of-image flush and result hand-off
// ----------------------------------------------------------------------------
module snpc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  snpc_pkg::status_t status,
  output snpc_pkg::cmd_t    cmd
);
  import snpc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = status.row_end ? ST_BELOW : ST_FILL;
        end
      end
      ST_FILL: begin
        if (status.row_end) begin
          state_nxt = ST_BELOW;
        end
      end
      ST_BELOW: begin
        if (status.row_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd.push      = 1'b0;
    cmd.use_input = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_tready     = 1'b1;
        cmd.push      = in_tvalid;
        cmd.use_input = 1'b1;
      end
      ST_FILL, ST_BELOW: begin
        cmd.push = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/snpc_datapath.sv
// ----------------------------------------------------------------------------
// snpc_datapath
// row buffer, 3x3 window, neighbour judge, saturating total and result register
// ----------------------------------------------------------------------------
`include "sparse_neighbor_pixel_counter_macros.svh"

module snpc_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int TOTAL_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_occupied,
  input  snpc_pkg::cmd_t                   cmd,
  output snpc_pkg::status_t                status,
  input  logic                             cfg_valid,
  input  logic [snpc_pkg::IDX_W-1:0]       cfg_index,
  input  logic [snpc_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [snpc_pkg::SUM_W-1:0]       out_tdata
);
  import snpc_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  function automatic logic [3:0] count_set(input logic [8:0] w);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 9; k++) begin
      n = n + 4'(w[k]);
    end
    return n;
  endfunction

  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [THRESH_W-1:0]    thresh_r;
  logic [1:0]             mem [MAX_WIDTH];
  logic [1:0]             rd_data_r;
  logic [8:0]             win_r, win_nxt;
  logic [CW-1:0]          col_r, col_nxt;
  logic [1:0]             rows_r, rows_nxt;
  logic [TOTAL_BITS-1:0]  total_r, total_nxt;
  logic                   out_valid_r;
  logic [SUM_W-1:0]       out_data_r;

  logic [31:0]            rw32, weff32, tot32;
  logic                   row_end, occ, top, mid, j1, j2;
  logic [8:0]             win1, win2;
  logic [1:0]             inc;
  logic [TOTAL_BITS:0]    sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      thresh_r    <= THRESH_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROW_WIDTH) begin
        row_width_r <= cfg_data[ROW_WIDTH_W-1:0];
      end else if (cfg_index == REG_THRESHOLD) begin
        thresh_r <= cfg_data[THRESH_W-1:0];
      end
    end
  end

  // effective width and end of row
  always_comb begin
    rw32 = 32'(row_width_r);
    if (rw32 == 32'd0) begin
      weff32 = 32'd1;
    end else if (rw32 > 32'(MAX_WIDTH)) begin
      weff32 = 32'(MAX_WIDTH);
    end else begin
      weff32 = rw32;
    end
    row_end = (32'(col_r) + 32'd1) >= weff32;
  end

  // window shift and judging of the centre pixel
  always_comb begin
    occ  = cmd.use_input & in_occupied;
    top  = rows_r[1] & rd_data_r[1];
    mid  = (rows_r != 2'd0) & rd_data_r[0];
    win1 = {occ, mid, top, win_r[8:3]};
    win2 = {3'b000, win1[8:3]};
    j1   = (col_r != '0) && (rows_r != 2'd0) && win1[4] &&
           (count_set(win1 & NB_MASK) < thresh_r);
    j2   = row_end && (rows_r != 2'd0) && win2[4] &&
           (count_set(win2 & NB_MASK) < thresh_r);
    inc  = {1'b0, j1} + {1'b0, j2};
    sum  = {1'b0, total_r} + (TOTAL_BITS+1)'(inc);
  end

  always_comb begin
    win_nxt   = win_r;
    col_nxt   = col_r;
    rows_nxt  = rows_r;
    total_nxt = total_r;
    if (cmd.emit) begin
      win_nxt   = '0;
      col_nxt   = '0;
      rows_nxt  = '0;
      total_nxt = '0;
    end else if (cmd.push) begin
      total_nxt = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      if (row_end) begin
        win_nxt  = '0;
        col_nxt  = '0;
        rows_nxt = rows_r[1] ? rows_r : rows_r + 2'd1;
      end else begin
        win_nxt = win1;
        col_nxt = CW'(32'(col_r) + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      col_r   <= '0;
      rows_r  <= '0;
      total_r <= '0;
    end else begin
      win_r   <= win_nxt;
      col_r   <= col_nxt;
      rows_r  <= rows_nxt;
      total_r <= total_nxt;
    end
  end

  // row buffer: write current column, read the next one
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[col_r] <= {mid, occ};
    end
    if (cmd.push && (col_nxt == col_r)) begin
      rd_data_r <= {mid, occ};
    end else begin
      rd_data_r <= mem[col_nxt];
    end
  end

  assign tot32 = 32'(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= tot32[SUM_W-1:0];
    end
  end

  assign status.row_end  = row_end;
  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;

  `SNPC_ASSERT_NEXT(a_emit_clears, cmd.emit, out_valid_r && total_r == '0 && rows_r == 2'd0, "emit did not clear image")
  `SNPC_ASSERT_NEXT(a_row_wrap, cmd.push && !cmd.emit && row_end, col_r == '0 && win_r == '0, "row end did not wrap")
  `SNPC_ASSERT_NEXT(a_total_sat, total_r == TOTAL_MAX && !cmd.emit, total_r == TOTAL_MAX, "total left saturation")
  `SNPC_ASSERT_NOW(a_emit_free, cmd.emit, !cmd.push, "emit during push")

endmodule

FILE: design/sparse_neighbor_pixel_counter.sv
// intake: one pixel per cycle while in_tready is high
// tlast: rest of its row and an empty row below are flushed, then the total is emitted
// the row buffer has a single write port and a single read port
// intake pauses during the end-of-image flush and until the previous total has been taken
// reset: synchronous active low, clears control and registers; row buffer not cleared
// ----------------------------------------------------------------------------
// sparse_neighbor_pixel_counter
// counts set pixels with few set neighbours in a row-ordered binary raster
// ----------------------------------------------------------------------------
module sparse_neighbor_pixel_counter #(
  parameter int MAX_WIDTH  = 256,
  parameter int TOTAL_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [0] occupied
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [snpc_pkg::SUM_W-1:0]     out_tdata,  // [23:0] sparse_total
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [snpc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [snpc_pkg::CFG_W-1:0]     cfg_data
);
  import snpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  snpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  snpc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_occupied (in_tdata[0]),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
